[sv/sdf_pkg.sv]
// Shared types and constants for the signed decimal field formatter.
`timescale 1ns / 1ps

package sdf_pkg;

    localparam int VALUE_W       = 32;
    localparam int FW_W          = 6;
    localparam int PREC_W        = 6;
    localparam int CHAR_W        = 8;
    localparam int LEN_W         = 7;   // holds any field length up to 64
    localparam int NDIG          = 10;  // decimal digits of a 32-bit magnitude
    localparam int DIG_IDX_W     = 4;
    localparam int DIGIT_W       = 4;
    localparam int PROD_W        = 64;
    localparam int RECIP_SHIFT   = 35;
    localparam int IN_DATA_W     = 48;
    localparam int OUT_DATA_W    = 8;
    localparam int MAX_FIELD_DEF = 63;

    // floor(x / 10) == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
    localparam logic [VALUE_W-1:0] RECIP = 32'hCCCC_CCCD;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

    typedef struct packed {
        logic                 done;
        logic [DIG_IDX_W-1:0] nd;
    } t_dig_stat;

    typedef struct packed {
        logic [CHAR_W-1:0]    sign_char;
        logic                 sign_n;
        logic [LEN_W-1:0]     pre;
        logic [LEN_W-1:0]     zeros;
        logic [DIG_IDX_W-1:0] nd;
        logic [LEN_W-1:0]     post;
        logic [LEN_W-1:0]     total;
    } t_layout;

endpackage

[sv/sdf_digit_unit.sv]
// Iterative divide-by-ten unit: one shared multiplier extracts decimal digits.
`timescale 1ns / 1ps

module sdf_digit_unit
    import sdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [VALUE_W-1:0]   i_mag,
    input  logic [DIG_IDX_W-1:0] i_rd_idx,
    output logic [DIGIT_W-1:0]   o_rd_digit,
    output t_dig_stat            o_stat
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_MUL,
        D_SUB
    } t_state;

    t_state               r_state;
    logic                 r_done;
    logic [DIG_IDX_W-1:0] r_nd;
    logic [VALUE_W-1:0]   r_mag;
    logic [PROD_W-1:0]    r_prod;
    logic [DIGIT_W-1:0]   r_digs [NDIG];

    logic [VALUE_W-1:0]   n_quot;
    logic [VALUE_W-1:0]   n_quot10;
    logic [VALUE_W-1:0]   n_rem;

    always_comb begin
        n_quot   = VALUE_W'(r_prod[PROD_W-1:RECIP_SHIFT]);
        n_quot10 = {n_quot[VALUE_W-4:0], 3'b000} + {n_quot[VALUE_W-2:0], 1'b0};
        n_rem    = r_mag - n_quot10;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_nd    <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_nd    <= '0;
                        r_state <= D_MUL;
                    end
                end
                D_MUL: begin
                    r_state <= D_SUB;
                end
                D_SUB: begin
                    r_nd <= r_nd + 1'b1;
                    if (n_quot == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_state <= D_MUL;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    // datapath: magnitude, product and digit store
    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_mag <= i_mag;
        end else if (r_state == D_SUB) begin
            r_mag <= n_quot;
        end
        if (r_state == D_MUL) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        end
        if (r_state == D_SUB) begin
            r_digs[r_nd] <= n_rem[DIGIT_W-1:0];
        end
    end

    assign o_rd_digit  = (i_rd_idx < DIG_IDX_W'(NDIG)) ? r_digs[i_rd_idx] : '0;
    assign o_stat.done = r_done;
    assign o_stat.nd   = r_nd;

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_SUB) |-> (n_rem < VALUE_W'(10)))
        else $error("remainder out of decimal range");

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_SUB) |-> (r_nd < DIG_IDX_W'(NDIG)))
        else $error("more than ten digits extracted");

endmodule

[sv/sdf_emitter.sv]
// Character emitter: walks pad, sign, zeros, digits, pad into an output register.
`timescale 1ns / 1ps

module sdf_emitter
    import sdf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_layout               i_layout,
    output logic [DIG_IDX_W-1:0]  o_rd_idx,
    input  logic [DIGIT_W-1:0]    i_rd_digit,
    output logic                  o_done,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic                  m_axis_tlast    // last
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_out_valid;
    logic [CHAR_W-1:0]    r_out_char;
    logic                 r_out_last;
    logic [LEN_W-1:0]     r_pre;
    logic                 r_sgn;
    logic [LEN_W-1:0]     r_zer;
    logic [DIG_IDX_W-1:0] r_dig;
    logic [LEN_W-1:0]     r_post;
    logic [LEN_W-1:0]     r_total;
    logic [CHAR_W-1:0]    r_sign_char;

    logic                 n_step;
    logic [CHAR_W-1:0]    n_char;

    assign n_step   = r_busy && (!r_out_valid || m_axis_tready);
    assign o_rd_idx = r_dig - 1'b1;

    always_comb begin
        if (r_pre != '0) begin
            n_char = CH_SPACE;
        end else if (r_sgn) begin
            n_char = r_sign_char;
        end else if (r_zer != '0) begin
            n_char = CH_ZERO;
        end else if (r_dig != '0) begin
            n_char = CH_ZERO + CHAR_W'(i_rd_digit);
        end else begin
            n_char = CH_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_start) begin
                r_busy      <= 1'b1;
                r_pre       <= i_layout.pre;
                r_sgn       <= i_layout.sign_n;
                r_zer       <= i_layout.zeros;
                r_dig       <= i_layout.nd;
                r_post      <= i_layout.post;
                r_total     <= i_layout.total;
                r_sign_char <= i_layout.sign_char;
            end else if (n_step) begin
                r_out_valid <= 1'b1;
                r_out_char  <= n_char;
                r_out_last  <= (r_total == LEN_W'(1));
                r_total     <= r_total - 1'b1;
                if (r_pre != '0) begin
                    r_pre <= r_pre - 1'b1;
                end else if (r_sgn) begin
                    r_sgn <= 1'b0;
                end else if (r_zer != '0) begin
                    r_zer <= r_zer - 1'b1;
                end else if (r_dig != '0) begin
                    r_dig <= r_dig - 1'b1;
                end else begin
                    r_post <= r_post - 1'b1;
                end
                if (r_total == LEN_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done        = r_done;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    a_busy_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_total != '0))
        else $error("emitter busy with nothing left");

    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> ((LEN_W+2)'(r_total) == (LEN_W+2)'(r_pre) + (LEN_W+2)'(r_sgn)
                    + (LEN_W+2)'(r_zer) + (LEN_W+2)'(r_dig) + (LEN_W+2)'(r_post)))
        else $error("remaining count does not match the parts");

endmodule

[sv/signed_decimal_field_formatter.sv]
// Top level of the signed decimal field formatter: input capture, layout and sequencing.
//
//  channel  | dir | tdata bits (low first)                                  | tlast
//  s_axis   | in  | value 32, field_width 6, precision 6, precision_given,  | -
//           |     | left_justify, force_sign, zero_pad (48 bits)            |
//  m_axis   | out | out_char 8                                              | last
//
// Per item: S_IDLE accepts it, then D decimal digits (1..10) are extracted in turn via
// the shared divide-by-ten multiplier (states D_MUL and D_SUB per digit) and the count is
// handed over; S_LAY1, S_LAY2 and S_LAY3 lay out the field, and S_EMIT sends N characters
// (0..MAX_FIELD) at one per cycle while m_axis is not stalled, then returns to idle.
// s_axis_tready is high only while idle. A stall on m_axis holds the emitter.
// Synchronous active-low reset returns everything to idle with no output valid.
`timescale 1ns / 1ps

module signed_decimal_field_formatter
    import sdf_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // value, field_width, precision,
                                                  // precision_given, left_justify,
                                                  // force_sign, zero_pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] out_char
    output logic                  m_axis_tlast    // last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIG,
        S_LAY1,
        S_LAY2,
        S_LAY3,
        S_EMIT
    } t_state;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD);

    t_state              r_state;
    logic                r_neg;
    logic                r_plus;
    logic                r_left;
    logic                r_zpad;
    logic                r_pgiven;
    logic                r_zero_case;
    logic [FW_W-1:0]     r_fw;
    logic [PREC_W-1:0]   r_prec;
    logic [LEN_W-1:0]    r_width;
    logic [LEN_W-1:0]    r_mindig;
    logic [DIG_IDX_W-1:0] r_nd;
    logic [LEN_W-1:0]    r_zeros;

    logic                 in_accept;
    logic [VALUE_W-1:0]   in_value;
    logic [VALUE_W-1:0]   in_mag;
    logic                 dig_start;
    t_dig_stat            dig_stat;
    logic [DIG_IDX_W-1:0] rd_idx;
    logic [DIGIT_W-1:0]   rd_digit;
    logic                 emit_start;
    logic                 emit_done;
    t_layout              layout;

    logic                 n_signlen;
    logic [LEN_W-1:0]     n_width;
    logic [LEN_W-1:0]     n_mindig;
    logic [LEN_W-1:0]     n_zeros;
    logic [LEN_W-1:0]     n_room;
    logic [LEN_W-1:0]     n_blen;
    logic [LEN_W-1:0]     n_pad;
    logic [LEN_W-1:0]     n_total;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_value      = s_axis_tdata[VALUE_W-1:0];
    // the most negative value wraps to its true unsigned magnitude
    assign in_mag        = in_value[VALUE_W-1] ? (VALUE_W'(0) - in_value) : in_value;
    assign dig_start     = in_accept;

    always_comb begin
        n_signlen = r_neg || r_plus;
        n_width   = (LEN_W'(r_fw) > MAX_LEN) ? MAX_LEN : LEN_W'(r_fw);
        if (r_pgiven) begin
            n_mindig = LEN_W'(r_prec);
        end else if (r_zpad && !r_left && n_width != '0) begin
            n_mindig = n_width - LEN_W'(n_signlen);
        end else begin
            n_mindig = '0;
        end
        n_room  = MAX_LEN - LEN_W'(n_signlen) - LEN_W'(r_nd);
        n_zeros = (r_mindig > LEN_W'(r_nd)) ? (r_mindig - LEN_W'(r_nd)) : '0;
        if (n_zeros > n_room) begin
            n_zeros = n_room;
        end
        n_blen  = LEN_W'(n_signlen) + r_zeros + LEN_W'(r_nd);
        n_pad   = (r_width > n_blen) ? (r_width - n_blen) : '0;
        n_total = n_blen + n_pad;
    end

    always_comb begin
        layout.sign_char = r_neg ? CH_MINUS : CH_PLUS;
        layout.sign_n    = n_signlen;
        layout.pre       = r_left ? '0 : n_pad;
        layout.zeros     = r_zeros;
        layout.nd        = r_nd;
        layout.post      = r_left ? n_pad : '0;
        layout.total     = n_total;
    end

    assign emit_start = (r_state == S_LAY3) && (n_total != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_DIG;
                    end
                end
                S_DIG: begin
                    if (dig_stat.done) begin
                        r_state <= S_LAY1;
                    end
                end
                S_LAY1: r_state <= S_LAY2;
                S_LAY2: r_state <= S_LAY3;
                S_LAY3: r_state <= (n_total != '0) ? S_EMIT : S_IDLE;
                S_EMIT: begin
                    if (emit_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // item fields and layout terms
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_neg       <= in_value[VALUE_W-1];
            r_fw        <= s_axis_tdata[VALUE_W +: FW_W];
            r_prec      <= s_axis_tdata[VALUE_W+FW_W +: PREC_W];
            r_pgiven    <= s_axis_tdata[VALUE_W+FW_W+PREC_W];
            r_left      <= s_axis_tdata[VALUE_W+FW_W+PREC_W+1];
            r_plus      <= s_axis_tdata[VALUE_W+FW_W+PREC_W+2];
            r_zpad      <= s_axis_tdata[VALUE_W+FW_W+PREC_W+3];
            r_zero_case <= s_axis_tdata[VALUE_W+FW_W+PREC_W]
                           && (s_axis_tdata[VALUE_W+FW_W +: PREC_W] == '0)
                           && (in_value == '0);
        end
        if (r_state == S_DIG && dig_stat.done) begin
            // zero printed at precision zero has no digits at all
            r_nd <= r_zero_case ? '0 : dig_stat.nd;
        end
        if (r_state == S_LAY1) begin
            r_width  <= n_width;
            r_mindig <= n_mindig;
        end
        if (r_state == S_LAY2) begin
            r_zeros <= n_zeros;
        end
    end

    sdf_digit_unit u_digit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (dig_start),
        .i_mag      (in_mag),
        .i_rd_idx   (rd_idx),
        .o_rd_digit (rd_digit),
        .o_stat     (dig_stat)
    );

    sdf_emitter u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (emit_start),
        .i_layout      (layout),
        .o_rd_idx      (rd_idx),
        .i_rd_digit    (rd_digit),
        .o_done        (emit_done),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_accept_to_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_DIG))
        else $error("accepted request did not start digit extraction");

    a_done_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_done |-> (r_state == S_EMIT))
        else $error("emitter finished outside the emit phase");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAY3) |-> (n_total <= MAX_LEN))
        else $error("field longer than the maximum");

endmodule

[sim/signed_decimal_field_formatter_test.sv]
// Self-checking testbench for the signed decimal field formatter (printf %d character stream).
`timescale 1ns / 1ps

module signed_decimal_field_formatter_test;
    import sdf_pkg::*;

    localparam int IDLE_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int LONG_HOLD  = 300;   // receiver hold-off used to back the block up
    localparam int DRAIN      = 64;

    // Declared high field first, so value lands in the low bits and it drops straight onto s_axis_tdata
    typedef struct packed {
        logic              zero_pad;
        logic              force_sign;
        logic              left_justify;
        logic              precision_given;
        logic [PREC_W-1:0] precision;
        logic [FW_W-1:0]   field_width;
        logic [VALUE_W-1:0] value;
    } t_fmt_req;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_fmt_char;

    class t_field_scoreboard;
        t_fmt_char   pending_chars [$];
        int unsigned errors   = 0;
        int unsigned requests = 0;
        int unsigned empties  = 0;
        int unsigned checked  = 0;
        int unsigned longest  = 0;

        // Works out the characters of one %d field and queues them
        function void note_request(t_fmt_req r);
            logic [VALUE_W-1:0] mag;
            logic [CHAR_W-1:0]  digs [NDIG];
            logic [CHAR_W-1:0]  body [$];
            int unsigned nd, signlen, mindig, zeros, room, width, pad;
            bit neg;
            neg   = r.value[VALUE_W-1];
            // unsigned negate, so the most negative value needs no special care
            mag   = neg ? (~r.value + 1'b1) : r.value;
            width = (r.field_width > MAX_FIELD_DEF) ? MAX_FIELD_DEF : r.field_width;
            nd    = 0;
            if (!(r.precision_given && r.precision == 0 && r.value == 0)) begin
                signlen = (neg || r.force_sign) ? 1 : 0;
                do begin
                    digs[nd] = CHAR_W'(CH_ZERO + mag % 10);
                    mag = mag / 10;
                    nd++;
                end while (mag != 0);
                if (r.precision_given) begin
                    mindig = r.precision;
                end else if (r.zero_pad && !r.left_justify && width > 0) begin
                    mindig = (width > signlen) ? width - signlen : 0;
                end else begin
                    mindig = 0;
                end
                zeros = (mindig > nd) ? mindig - nd : 0;
                room  = MAX_FIELD_DEF - signlen - nd;
                if (zeros > room) zeros = room;
                if (neg) begin
                    body.push_back(CH_MINUS);
                end else if (r.force_sign) begin
                    body.push_back(CH_PLUS);
                end
                repeat (zeros) body.push_back(CH_ZERO);
                for (int i = int'(nd) - 1; i >= 0; i--) body.push_back(digs[i]);
            end else if (r.force_sign) begin
                body.push_back(CH_PLUS);
            end
            pad = (width > body.size()) ? width - body.size() : 0;
            if (r.left_justify) begin
                repeat (pad) body.push_back(CH_SPACE);
            end else begin
                repeat (pad) body.push_front(CH_SPACE);
            end
            foreach (body[i]) begin
                pending_chars.push_back('{ch: body[i], last: (i == body.size() - 1)});
            end
            requests++;
            if (body.size() == 0) empties++;
            if (body.size() > longest) longest = body.size();
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic lst);
            t_fmt_char e;
            checked++;
            if (pending_chars.size() == 0) begin
                $error("out_char: no character expected, got 0x%02h (last %0b)", ch, lst);
                errors++;
                return;
            end
            e = pending_chars.pop_front();
            if (ch !== e.ch) begin
                $error("out_char: expected 0x%02h, actual 0x%02h", e.ch, ch);
                errors++;
            end
            if (lst !== e.last) begin
                $error("last: expected %0b, actual %0b", e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;   // value, field_width, precision,
                                                 // precision_given, left_justify,
                                                 // force_sign, zero_pad
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [7:0] out_char
    logic                  m_axis_tlast;         // last

    t_field_scoreboard board = new();
    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 51;
    bit          hold_req      = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned idle_cycles   = 0;

    signed_decimal_field_formatter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_fmt_req mk_req(logic [VALUE_W-1:0] v, int fw, int pr,
                                        bit pg, bit lj, bit fs, bit zp);
        t_fmt_req r;
        r.value           = v;
        r.field_width     = FW_W'(fw);
        r.precision       = PREC_W'(pr);
        r.precision_given = pg;
        r.left_justify    = lj;
        r.force_sign      = fs;
        r.zero_pad        = zp;
        return r;
    endfunction

    function automatic t_fmt_req random_request();
        t_fmt_req          r;
        logic [VALUE_W-1:0] lim;
        case ($urandom_range(4))
            0: r.value = $urandom;
            1: r.value = $urandom_range(40) - 20;
            2: begin
                // uniform over digit counts rather than over values
                lim = 1;
                repeat ($urandom_range(9, 1)) lim = lim * 10;
                r.value = $urandom_range(lim - 1);
                if ($urandom_range(1)) r.value = -r.value;
            end
            3: begin
                case ($urandom_range(5))
                    0: r.value = 32'h8000_0000;
                    1: r.value = 32'h7FFF_FFFF;
                    2: r.value = 32'h8000_0001;
                    3: r.value = 32'hFFFF_FFFF;
                    4: r.value = 32'd1;
                    default: r.value = '0;
                endcase
            end
            default: r.value = $urandom_range(1) ? 32'd0 : $urandom_range(9);
        endcase
        // mostly narrow fields, now and then the full range
        r.field_width     = FW_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                           : $urandom_range(16));
        r.precision       = PREC_W'(($urandom_range(9) == 0) ? $urandom_range(63)
                                                             : $urandom_range(12));
        r.precision_given = ($urandom_range(2) == 0);
        r.left_justify    = 1'($urandom_range(1));
        r.force_sign      = 1'($urandom_range(1));
        r.zero_pad        = 1'($urandom_range(1));
        return r;
    endfunction

    task automatic send_request(t_fmt_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom});
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(r);
    endtask

    // Receiver: checks each character and decides tready for the next cycle
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                board.check_char(m_axis_tdata[CHAR_W-1:0], m_axis_tlast);
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no request or character moved for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero with and without digits, padding around an empty body
        send_request(mk_req(0, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(0, 0, 0, 1, 0, 0, 0));
        send_request(mk_req(0, 0, 0, 1, 0, 1, 0));
        send_request(mk_req(0, 5, 0, 1, 0, 0, 0));
        send_request(mk_req(0, 4, 0, 1, 1, 1, 0));
        send_request(mk_req(0, 6, 0, 1, 0, 0, 1));
        // extremes of the value
        send_request(mk_req(32'h8000_0000, 0, 0, 0, 0, 0, 0));
        send_request(mk_req(32'h7FFF_FFFF, 0, 0, 0, 0, 1, 0));
        send_request(mk_req(1000000000, 0, 0, 0, 0, 0, 0));
        // zero fill to the width, and where it is overridden
        send_request(mk_req(-1, 10, 0, 0, 0, 0, 1));
        send_request(mk_req(42, 8, 0, 0, 0, 1, 1));
        send_request(mk_req(42, 8, 0, 0, 1, 0, 1));
        send_request(mk_req(42, 8, 3, 1, 0, 0, 1));
        send_request(mk_req(-7, 3, 0, 0, 0, 0, 1));
        send_request(mk_req(0, 1, 0, 0, 0, 1, 1));
        send_request(mk_req(0, 0, 0, 0, 0, 0, 1));
        // widest fields and precisions that get cut back
        send_request(mk_req(7, 63, 0, 0, 0, 0, 0));
        send_request(mk_req(32'h8000_0000, 63, 0, 0, 0, 0, 1));
        send_request(mk_req(5, 0, 63, 1, 0, 1, 0));
        send_request(mk_req(32'h8000_0000, 0, 62, 1, 0, 0, 0));
        send_request(mk_req(-123, 63, 0, 0, 1, 0, 0));
        send_request(mk_req(123, 2, 0, 0, 0, 0, 0));
        send_request(mk_req(99, 10, 5, 1, 1, 1, 0));

        repeat (115) send_request(random_request());

        send_idle_pct = 51;
        recv_idle_pct = 26;
        repeat (115) send_request(random_request());

        // no idling; receiver backs off for a long stretch to stall the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        repeat (116) send_request(random_request());
        s_axis_tvalid <= 1'b0;

        while (board.pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (board.pending_chars.size() != 0) begin
            $error("%0d characters never arrived", board.pending_chars.size());
            board.errors++;
        end

        $display("Formatted %0d fields (%0d empty, longest %0d chars), %0d characters checked",
                 board.requests, board.empties, board.longest, board.checked);
        $display("Flow control: mixed idling both ways, then back-to-back with a long stall");
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
